### hdl/ppt_pkg.sv
// ppt_pkg: shared types and constants of the ping-pong trace buffer
// field widths, operation codes, register indexes and the command and
// status structs between controller and datapath; no dependencies
package ppt_pkg;

  // fixed field widths
  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 12;
  localparam int POS_W  = 13;
  localparam int RLEN_W = 7;
  localparam int TOT_W  = 13;
  localparam int CFG_W  = 12;
  localparam int CIDX_W = 1;

  // operation codes; code 3 is unused and only reports status
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } ppt_op_t;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_RING_MODE    = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_SWITCH_LEVEL = 1'b1;

  localparam logic [LEN_W-1:0] SWITCH_LEVEL_RST = 12'd3072;

  // controller to datapath
  typedef struct packed {
    logic accept;   // take the input beat
    logic issue;    // issue one store read of a burst
    logic load_rd;  // move read data into the output register
  } ppt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic burst;      // input beat is a read that returns data
    logic rem_nz;     // burst reads still to issue
    logic dv;         // read data waiting
    logic last_pend;  // waiting read data is the final byte
  } ppt_sts_t;

endpackage

### hdl/ppt_ctrl.sv
// ppt_ctrl: controller state machine of the ping-pong trace buffer
// sequences input beats and read bursts; uses ppt_pkg command and status
module ppt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ppt_pkg::ppt_sts_t sts,
  output ppt_pkg::ppt_cmd_t cmd
);
  import ppt_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // commands; the input side stays stalled while reset is held
  always_comb begin
    cmd.accept  = rst_n && (state_r == ST_IDLE) && in_valid && sts.out_free;
    cmd.issue   = (state_r == ST_READ) && sts.rem_nz && (!sts.dv || sts.out_free);
    cmd.load_rd = (state_r == ST_READ) && sts.dv && sts.out_free;
    in_stall    = !(rst_n && (state_r == ST_IDLE) && sts.out_free);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept && sts.burst) state_nxt = ST_READ;
      end
      ST_READ: begin
        if (cmd.load_rd && sts.last_pend) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/ppt_datapath.sv
// ppt_datapath: trace store, fill levels, burst counters and output register
// executes controller commands; uses ppt_pkg types and constants
module ppt_datapath #(
  parameter int HALF_DEPTH     = 4096,
  parameter int MAX_READ_BURST = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ppt_pkg::ppt_cmd_t           cmd,
  output ppt_pkg::ppt_sts_t           sts,
  input  logic                        cfg_we,
  input  logic [ppt_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [ppt_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic [ppt_pkg::OP_W-1:0]    in_op,
  input  logic [ppt_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic [ppt_pkg::LEN_W-1:0]   in_record_length,
  input  logic                        in_first_of_record,
  input  logic                        in_last_of_record,
  input  logic [ppt_pkg::POS_W-1:0]   in_read_position,
  input  logic [ppt_pkg::RLEN_W-1:0]  in_read_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ppt_pkg::BYTE_W-1:0]  out_read_byte,
  output logic                        out_read_valid,
  output logic                        out_last_result,
  output logic [ppt_pkg::TOT_W-1:0]   out_total_size,
  output logic                        out_write_accepted,
  output logic                        out_switched
);
  import ppt_pkg::*;

  localparam int FW = $clog2(HALF_DEPTH);
  localparam int TW = FW + 1;
  localparam int AW = $clog2(2 * HALF_DEPTH);
  localparam int CW = ((TW > POS_W) ? TW : POS_W) + 1;
  localparam int RW = $clog2(MAX_READ_BURST + 1);

  // state
  logic [FW-1:0]     fill_r [2];
  logic [FW-1:0]     fill_nxt [2];
  logic              active_r, active_nxt;
  logic              taken_r, taken_nxt;
  logic              ring_r;
  logic [LEN_W-1:0]  swlvl_r;
  logic [TW-1:0]     pos_r;
  logic [RW-1:0]     rem_r;
  logic              dv_r, last_pend_r;
  logic [BYTE_W-1:0] rdata_r;
  logic [BYTE_W-1:0] mem [2*HALF_DEPTH];

  logic              out_valid_r;
  logic [BYTE_W-1:0] byte_r;
  logic              rvalid_r, last_r, acc_r, sw_r;
  logic [TOT_W-1:0]  total_r;

  logic [FW-1:0]     fill_a, fill_o, fill_a_new;
  logic [TW-1:0]     total, total_nxt;
  logic              taken_eff, room, do_switch, we, load_st;
  logic [AW-1:0]     waddr, raddr;
  logic [RLEN_W-1:0] len_sat;
  logic [CW-1:0]     avail, n_bytes;
  logic              rd_burst;
  logic              out_free;

  function automatic logic [AW-1:0] half_base(input logic h);
    half_base = h ? AW'(HALF_DEPTH) : '0;
  endfunction

  assign fill_a = fill_r[active_r];
  assign fill_o = fill_r[~active_r];
  assign total  = TW'(fill_r[0]) + TW'(fill_r[1]);

  // append decision
  always_comb begin
    taken_eff  = in_first_of_record
               ? ((CW'(fill_a) + CW'(in_record_length)) < CW'(HALF_DEPTH)) : taken_r;
    room       = (CW'(fill_a) + CW'(1)) < CW'(HALF_DEPTH);
    fill_a_new = (taken_eff && room) ? fill_a + FW'(1) : fill_a;
    do_switch  = taken_eff && in_last_of_record && ring_r
               && (CW'(fill_a_new) >= CW'(swlvl_r));
    waddr      = half_base(active_r) + AW'(fill_a);
    we         = cmd.accept && (in_op == OP_APPEND) && taken_eff && room;
  end

  // state update for the accepted beat
  always_comb begin
    fill_nxt[0] = fill_r[0];
    fill_nxt[1] = fill_r[1];
    active_nxt  = active_r;
    taken_nxt   = taken_r;
    unique case (in_op)
      OP_APPEND: begin
        fill_nxt[active_r] = fill_a_new;
        taken_nxt          = taken_eff && !in_last_of_record;
        if (do_switch) begin
          active_nxt          = ~active_r;
          fill_nxt[~active_r] = '0;
        end
      end
      OP_CLEAR: begin
        fill_nxt[0] = '0;
        fill_nxt[1] = '0;
        active_nxt  = 1'b0;
        taken_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
    total_nxt = TW'(fill_nxt[0]) + TW'(fill_nxt[1]);
  end

  // read request range
  always_comb begin
    len_sat  = (in_read_length > RLEN_W'(MAX_READ_BURST))
             ? RLEN_W'(MAX_READ_BURST) : in_read_length;
    rd_burst = (in_op == OP_READ) && (len_sat != '0)
             && (CW'(in_read_position) < CW'(total));
    avail    = CW'(total) - CW'(in_read_position);
    n_bytes  = (avail < CW'(len_sat)) ? avail : CW'(len_sat);
  end

  // logical position to store address: older half first, then active half
  always_comb begin
    if (pos_r < TW'(fill_o)) raddr = half_base(~active_r) + AW'(pos_r);
    else                     raddr = half_base(active_r) + AW'(pos_r - TW'(fill_o));
  end

  assign out_free      = !out_valid_r || !out_stall;
  assign load_st       = cmd.accept && !sts.burst;
  assign sts.out_free  = out_free;
  assign sts.burst     = rd_burst;
  assign sts.rem_nz    = (rem_r != '0);
  assign sts.dv        = dv_r;
  assign sts.last_pend = last_pend_r;

  // trace store
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= in_data_byte;
    if (cmd.issue) rdata_r <= mem[raddr];
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r[0]   <= '0;
      fill_r[1]   <= '0;
      active_r    <= 1'b0;
      taken_r     <= 1'b0;
      ring_r      <= 1'b0;
      swlvl_r     <= SWITCH_LEVEL_RST;
      rem_r       <= '0;
      dv_r        <= 1'b0;
      last_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RING_MODE:    ring_r  <= cfg_wdata[0];
          CFG_SWITCH_LEVEL: swlvl_r <= cfg_wdata[LEN_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.accept) begin
        fill_r[0] <= fill_nxt[0];
        fill_r[1] <= fill_nxt[1];
        active_r  <= active_nxt;
        taken_r   <= taken_nxt;
        if (sts.burst) rem_r <= RW'(n_bytes);
      end
      if (cmd.issue) begin
        rem_r       <= rem_r - RW'(1);
        dv_r        <= 1'b1;
        last_pend_r <= (rem_r == RW'(1));
      end else if (cmd.load_rd) begin
        dv_r <= 1'b0;
      end
      if (load_st || cmd.load_rd) out_valid_r <= 1'b1;
      else if (!out_stall)        out_valid_r <= 1'b0;
    end
  end

  // burst position
  always_ff @(posedge clk) begin
    if (cmd.accept && sts.burst) pos_r <= TW'(in_read_position);
    else if (cmd.issue)          pos_r <= pos_r + TW'(1);
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_st) begin
      byte_r   <= '0;
      rvalid_r <= 1'b0;
      last_r   <= 1'b1;
      total_r  <= TOT_W'(total_nxt);
      acc_r    <= (in_op == OP_APPEND) ? taken_eff : taken_nxt;
      sw_r     <= (in_op == OP_APPEND) && do_switch;
    end else if (cmd.load_rd) begin
      byte_r   <= rdata_r;
      rvalid_r <= 1'b1;
      last_r   <= last_pend_r;
      total_r  <= TOT_W'(total);
      acc_r    <= taken_r;
      sw_r     <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_byte      = byte_r;
  assign out_read_valid     = rvalid_r;
  assign out_last_result    = last_r;
  assign out_total_size     = total_r;
  assign out_write_accepted = acc_r;
  assign out_switched       = sw_r;

`ifndef SYNTH
  a_issue_rem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> rem_r != '0)
    else $error("burst read issued with no bytes left");
  a_load_dv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_rd |-> dv_r)
    else $error("read result loaded without read data");
  a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> (!dv_r && rem_r == '0))
    else $error("input beat taken while a burst is in flight");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(fill_r[0]) < CW'(HALF_DEPTH)) && (CW'(fill_r[1]) < CW'(HALF_DEPTH)))
    else $error("fill level reached half size");
`endif

endmodule

### hdl/ping_pong_trace_buffer_unit.sv
// ping_pong_trace_buffer_unit: top level of the two-half trace log
// joins ppt_ctrl and ppt_datapath; uses ppt_pkg
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | op, byte, lengths, marks, position
//   out_    | output    | out_valid/out_stall | byte, valid, last, total, status
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// append, clear and other ops give one result beat each
// a read of n bytes gives n beats through one store read port, one
// byte a cycle while the output is not stalled; the store read is registered
// reset is synchronous and stalls the input; no clearing pass, the store holds no reset value
// a stalled output holds its beat and stalls the input side
module ping_pong_trace_buffer_unit #(
  parameter int HALF_DEPTH     = 4096,
  parameter int MAX_READ_BURST = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ppt_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [ppt_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ppt_pkg::OP_W-1:0]    in_op,
  input  logic [ppt_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic [ppt_pkg::LEN_W-1:0]   in_record_length,
  input  logic                        in_first_of_record,
  input  logic                        in_last_of_record,
  input  logic [ppt_pkg::POS_W-1:0]   in_read_position,
  input  logic [ppt_pkg::RLEN_W-1:0]  in_read_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ppt_pkg::BYTE_W-1:0]  out_read_byte,
  output logic                        out_read_valid,
  output logic                        out_last_result,
  output logic [ppt_pkg::TOT_W-1:0]   out_total_size,
  output logic                        out_write_accepted,
  output logic                        out_switched
);
  import ppt_pkg::*;

  ppt_cmd_t cmd;
  ppt_sts_t sts;

  // controller
  ppt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  ppt_datapath #(
    .HALF_DEPTH     (HALF_DEPTH),
    .MAX_READ_BURST (MAX_READ_BURST)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_op              (in_op),
    .in_data_byte       (in_data_byte),
    .in_record_length   (in_record_length),
    .in_first_of_record (in_first_of_record),
    .in_last_of_record  (in_last_of_record),
    .in_read_position   (in_read_position),
    .in_read_length     (in_read_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_read_byte      (out_read_byte),
    .out_read_valid     (out_read_valid),
    .out_last_result    (out_last_result),
    .out_total_size     (out_total_size),
    .out_write_accepted (out_write_accepted),
    .out_switched       (out_switched)
  );

endmodule

### verif/ping_pong_trace_buffer_unit_test.sv
// ping_pong_trace_buffer_unit_test: self-checking bench for the two-half trace log
// drives appends, reads and clears against a behavioral predictor of both halves;
// depends on ppt_pkg and ping_pong_trace_buffer_unit
module ping_pong_trace_buffer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ppt_pkg::*;

  localparam int HALF_SIZE     = 4096;
  localparam int READ_BURST    = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  rec_len;
    logic              first;
    logic              last;
    logic [POS_W-1:0]  pos;
    logic [RLEN_W-1:0] rlen;
  } trace_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rbyte;
    logic              rvalid;
    logic              last;
    logic [TOT_W-1:0]  total;
    logic              acc;
    logic              sw;
  } log_result_t;

  typedef struct packed {
    logic              is_cfg;
    logic [CIDX_W-1:0] idx;
    logic [CFG_W-1:0]  val;
    trace_beat_t       beat;
    logic              typed;
    log_result_t       want;
  } plan_row_t;

  // dut ports
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_op = '0;
  logic [BYTE_W-1:0]   in_data_byte = '0;
  logic [LEN_W-1:0]    in_record_length = '0;
  logic                in_first_of_record = 1'b0;
  logic                in_last_of_record = 1'b0;
  logic [POS_W-1:0]    in_read_position = '0;
  logic [RLEN_W-1:0]   in_read_length = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [BYTE_W-1:0]   out_read_byte;
  logic                out_read_valid;
  logic                out_last_result;
  logic [TOT_W-1:0]    out_total_size;
  logic                out_write_accepted;
  logic                out_switched;

  // predictor state: both halves, fills, active half, open record, registers
  logic [BYTE_W-1:0]   trace_mem [2*HALF_SIZE];
  int unsigned         half_fill [2] = '{0, 0};
  int unsigned         act_half = 0;
  logic                rec_open = 1'b0;
  logic                ring_en = 1'b0;
  logic [CFG_W-1:0]    sw_level = SWITCH_LEVEL_RST;

  log_result_t         predicted_beats [$];
  log_result_t         expected_beats [$];
  plan_row_t           plan [$];

  int unsigned         beats_sent = 0;
  int unsigned         fail_count = 0;
  int unsigned         send_idle_pct = 0;
  int unsigned         stall_pct = 0;
  int unsigned         hold_asks = 0;
  int unsigned         hold_done = 0;
  int unsigned         hold_left = 0;
  int unsigned         cycle_count = 0;

  ping_pong_trace_buffer_unit #(
    .HALF_DEPTH(HALF_SIZE),
    .MAX_READ_BURST(READ_BURST)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_data_byte(in_data_byte),
    .in_record_length(in_record_length),
    .in_first_of_record(in_first_of_record),
    .in_last_of_record(in_last_of_record),
    .in_read_position(in_read_position),
    .in_read_length(in_read_length),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_read_byte(out_read_byte),
    .out_read_valid(out_read_valid),
    .out_last_result(out_last_result),
    .out_total_size(out_total_size),
    .out_write_accepted(out_write_accepted),
    .out_switched(out_switched)
  );

  always #5 clk = ~clk;

  function automatic int unsigned fill_sum();
    return half_fill[0] + half_fill[1];
  endfunction

  function automatic void note_result(logic [BYTE_W-1:0] rb, logic rv, logic lst, logic acc,
                                      logic sw);
    log_result_t r;
    r.rbyte = rb;
    r.rvalid = rv;
    r.last = lst;
    r.total = TOT_W'(fill_sum());
    r.acc = acc;
    r.sw = sw;
    predicted_beats.push_back(r);
  endfunction

  // apply one accepted input beat to the predictor and list its result beats
  function automatic void predict_trace_op(trace_beat_t b);
    int unsigned a, o, total, rl, n, p;
    logic acc, sw;
    logic [BYTE_W-1:0] rb;
    predicted_beats.delete();
    a = act_half;
    sw = 1'b0;
    case (b.op)
      OP_APPEND: begin
        // the first byte decides whether the whole record fits
        if (b.first) rec_open = (half_fill[a] + b.rec_len) < HALF_SIZE;
        acc = rec_open;
        if (rec_open) begin
          if (half_fill[a] + 1 < HALF_SIZE) begin
            trace_mem[a*HALF_SIZE + half_fill[a]] = b.data;
            half_fill[a]++;
          end
          if (b.last) begin
            if (ring_en && half_fill[a] >= sw_level) begin
              a ^= 1;
              act_half = a;
              half_fill[a] = 0;
              sw = 1'b1;
            end
            rec_open = 1'b0;
          end
        end
        note_result('0, 1'b0, 1'b1, acc, sw);
      end
      OP_READ: begin
        // older half first, then the active half
        o = a ^ 1;
        total = fill_sum();
        rl = (b.rlen > READ_BURST) ? READ_BURST : b.rlen;
        if (rl == 0 || b.pos >= total) begin
          note_result('0, 1'b0, 1'b1, rec_open, 1'b0);
        end else begin
          n = total - b.pos;
          if (n > rl) n = rl;
          for (int unsigned k = 0; k < n; k++) begin
            p = b.pos + k;
            if (p < half_fill[o]) rb = trace_mem[o*HALF_SIZE + p];
            else rb = trace_mem[a*HALF_SIZE + p - half_fill[o]];
            note_result(rb, 1'b1, k + 1 == n, rec_open, 1'b0);
          end
        end
      end
      OP_CLEAR: begin
        half_fill[0] = 0;
        half_fill[1] = 0;
        act_half = 0;
        rec_open = 1'b0;
        note_result('0, 1'b0, 1'b1, 1'b0, 1'b0);
      end
      default: begin
        note_result('0, 1'b0, 1'b1, rec_open, 1'b0);
      end
    endcase
  endfunction

  function automatic void check_field(string what, logic [TOT_W-1:0] want,
                                      logic [TOT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // receiver: check each accepted result beat, then pick the next stall
  always @(posedge clk) begin
    log_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, got byte %0d total %0d",
                 $time, out_read_byte, out_total_size);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        check_field("read_byte", want.rbyte, out_read_byte);
        check_field("read_valid", want.rvalid, out_read_valid);
        check_field("last_result", want.last, out_last_result);
        check_field("total_size", want.total, out_total_size);
        check_field("write_accepted", want.acc, out_write_accepted);
        check_field("switched", want.sw, out_switched);
      end
    end
    // a long hold-off starts when the stimulus asks for one
    if (hold_asks != hold_done) begin
      hold_done = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // sender: optional idle cycles, then hold the beat until it is taken
  task automatic send_beat(trace_beat_t b, logic typed = 1'b0, log_result_t want = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= b.op;
    in_data_byte <= b.data;
    in_record_length <= b.rec_len;
    in_first_of_record <= b.first;
    in_last_of_record <= b.last;
    in_read_position <= b.pos;
    in_read_length <= b.rlen;
    do @(posedge clk); while (in_stall);
    predict_trace_op(b);
    if (typed) expected_beats.push_back(want);
    else foreach (predicted_beats[i]) expected_beats.push_back(predicted_beats[i]);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register writes only happen once the block has gone quiet
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_RING_MODE) ring_en = val[0];
    else sw_level = val;
  endtask

  function automatic trace_beat_t noise_beat();
    trace_beat_t b;
    b.op = OP_W'($urandom_range(3));
    b.data = BYTE_W'($urandom);
    b.rec_len = LEN_W'($urandom);
    b.first = 1'($urandom);
    b.last = 1'($urandom);
    b.pos = POS_W'($urandom);
    b.rlen = RLEN_W'($urandom_range(127));
    return b;
  endfunction

  // reads mostly inside the log, some at its end, some anywhere
  function automatic trace_beat_t read_beat();
    trace_beat_t b;
    int unsigned pick, total;
    b = noise_beat();
    b.op = OP_READ;
    total = fill_sum();
    pick = $urandom_range(99);
    if (pick < 70) b.pos = POS_W'($urandom_range(total));
    else if (pick < 85) b.pos = POS_W'(total + $urandom_range(2) - 1);
    pick = $urandom_range(99);
    if (pick < 60) b.rlen = RLEN_W'($urandom_range(8, 1));
    else if (pick < 85) b.rlen = RLEN_W'($urandom_range(READ_BURST, 1));
    return b;
  endfunction

  function automatic plan_row_t op_row(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                       logic [LEN_W-1:0] len, logic first, logic last,
                                       logic [POS_W-1:0] pos, logic [RLEN_W-1:0] rlen);
    plan_row_t r;
    r = '0;
    r.beat.op = op;
    r.beat.data = data;
    r.beat.rec_len = len;
    r.beat.first = first;
    r.beat.last = last;
    r.beat.pos = pos;
    r.beat.rlen = rlen;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  // single status beat whose value is obvious by hand
  function automatic plan_row_t with_status(plan_row_t r, logic [TOT_W-1:0] total, logic acc);
    r.typed = 1'b1;
    r.want = '0;
    r.want.last = 1'b1;
    r.want.total = total;
    r.want.acc = acc;
    return r;
  endfunction

  // random mix: mostly framed records and reads, some broken records, clears, unused-op beats and noise
  task automatic random_beats(int unsigned count);
    int unsigned start, nbytes, pick, brk;
    logic [LEN_W-1:0] said_len;
    trace_beat_t b;
    start = beats_sent;
    while (beats_sent - start < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        nbytes = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        brk = $urandom_range(99);
        said_len = LEN_W'(nbytes);
        if (brk < 6) said_len = LEN_W'($urandom);
        else if (brk < 10) said_len = '0;
        for (int unsigned k = 0; k < nbytes; k++) begin
          b = noise_beat();
          b.op = OP_APPEND;
          b.first = (k == 0) && !(brk >= 10 && brk < 18);
          b.last = (k == nbytes - 1) && !(brk >= 18 && brk < 26);
          if (b.first) b.rec_len = said_len;
          send_beat(b);
        end
        // a stray byte after the record closed
        if (brk >= 26 && brk < 32) begin
          b = noise_beat();
          b.op = OP_APPEND;
          b.first = 1'b0;
          b.last = 1'b0;
          send_beat(b);
        end
      end else if (pick < 85) begin
        send_beat(read_beat());
      end else if (pick < 88) begin
        b = noise_beat();
        b.op = OP_CLEAR;
        send_beat(b);
      end else if (pick < 91) begin
        b = noise_beat();
        b.op = OP_UNUSED;
        send_beat(b);
      end else begin
        send_beat(noise_beat());
      end
    end
  endtask

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ping_pong_trace_buffer_unit regression: fail");
    $finish;
  end

  initial begin
    trace_beat_t b;
    logic [CFG_W-1:0] lvl;
    int unsigned idle_mix [4];
    int unsigned stall_mix [4];
    int unsigned brim_pos [7];
    idle_mix = '{0, 64, 0, 28};
    stall_mix = '{0, 0, 64, 28};
    brim_pos = '{4094, 4095, 4096, 8189, 8190, 8191, 0};

    // directed rows: empty log, extremes, rejection, stray bytes, open record
    plan.push_back(with_status(op_row(OP_READ, 8'h00, 12'd0, 1'b0, 1'b0, 13'd0, 7'd1),
                               13'd0, 1'b0));
    plan.push_back(with_status(op_row(OP_UNUSED, 8'hFF, 12'hFFF, 1'b1, 1'b1, 13'h1FFF,
                                      7'h7F), 13'd0, 1'b0));
    plan.push_back(with_status(op_row(OP_APPEND, 8'hFF, 12'd4095, 1'b1, 1'b0, 13'd0, 7'd0),
                               13'd1, 1'b1));
    plan.push_back(with_status(op_row(OP_APPEND, 8'h00, 12'd0, 1'b0, 1'b1, 13'd0, 7'd0),
                               13'd2, 1'b1));
    plan.push_back(with_status(op_row(OP_APPEND, 8'hA5, 12'd4095, 1'b1, 1'b1, 13'd0, 7'd0),
                               13'd2, 1'b0));
    plan.push_back(with_status(op_row(OP_APPEND, 8'h5A, 12'd7, 1'b0, 1'b0, 13'd0, 7'd0),
                               13'd2, 1'b0));
    plan.push_back(op_row(OP_APPEND, 8'h3C, 12'd0, 1'b1, 1'b1, 13'd0, 7'd0));
    plan.push_back(with_status(op_row(OP_READ, 8'h00, 12'd0, 1'b0, 1'b0, 13'd0, 7'd0),
                               13'd3, 1'b0));
    plan.push_back(op_row(OP_READ, 8'h00, 12'd0, 1'b0, 1'b0, 13'd0, 7'd127));
    plan.push_back(op_row(OP_READ, 8'h00, 12'd0, 1'b0, 1'b0, 13'd2, 7'd64));
    plan.push_back(with_status(op_row(OP_READ, 8'h00, 12'd0, 1'b0, 1'b0, 13'd3, 7'd1),
                               13'd3, 1'b0));
    plan.push_back(with_status(op_row(OP_READ, 8'h00, 12'd0, 1'b0, 1'b0, 13'd8191, 7'd64),
                               13'd3, 1'b0));
    plan.push_back(op_row(OP_APPEND, 8'h81, 12'd1, 1'b1, 1'b0, 13'd0, 7'd0));
    plan.push_back(op_row(OP_READ, 8'h00, 12'd0, 1'b0, 1'b0, 13'd1, 7'd64));
    plan.push_back(op_row(OP_APPEND, 8'h7E, 12'd0, 1'b0, 1'b0, 13'd0, 7'd0));
    plan.push_back(with_status(op_row(OP_CLEAR, 8'h00, 12'd0, 1'b0, 1'b0, 13'd0, 7'd0),
                               13'd0, 1'b0));
    plan.push_back(with_status(op_row(OP_APPEND, 8'h99, 12'd1, 1'b0, 1'b1, 13'd0, 7'd0),
                               13'd0, 1'b0));
    // switch level zero: every accepted record flips the half
    plan.push_back(cfg_row(CFG_RING_MODE, 12'd1));
    plan.push_back(cfg_row(CFG_SWITCH_LEVEL, 12'd0));
    plan.push_back(op_row(OP_APPEND, 8'h11, 12'd2, 1'b1, 1'b1, 13'd0, 7'd0));
    plan.push_back(op_row(OP_APPEND, 8'h22, 12'd4095, 1'b1, 1'b1, 13'd0, 7'd0));
    plan.push_back(op_row(OP_READ, 8'h00, 12'd0, 1'b0, 1'b0, 13'd0, 7'd64));
    plan.push_back(cfg_row(CFG_SWITCH_LEVEL, 12'd4095));
    plan.push_back(cfg_row(CFG_RING_MODE, 12'd0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].val);
      else send_beat(plan[i].beat, plan[i].typed, plan[i].want);
    end

    // reads near the half boundary, at the top of the position range and at zero, then random reads
    foreach (brim_pos[i]) begin
      b = read_beat();
      b.pos = POS_W'(brim_pos[i]);
      b.rlen = RLEN_W'(READ_BURST);
      send_beat(b);
    end
    repeat (20) send_beat(read_beat());
    b = noise_beat();
    b.op = OP_CLEAR;
    send_beat(b);

    // random phases over the idle and stall mixes and several register settings
    for (int unsigned ph = 0; ph < 8; ph++) begin
      case (ph)
        0: lvl = 12'd1;
        1: lvl = 12'd0;
        2: lvl = 12'd4095;
        default: lvl = CFG_W'($urandom_range(48, 2));
      endcase
      write_reg(CFG_RING_MODE, CFG_W'(ph != 5));
      write_reg(CFG_SWITCH_LEVEL, lvl);
      send_idle_pct = idle_mix[ph % 4];
      stall_pct <= stall_mix[ph % 4];
      // receiver holds off while the sender keeps offering beats
      if (ph == 0) hold_asks <= hold_asks + 1;
      random_beats(38);
    end

    drain();
    if (fail_count == 0) begin
      $display("ping_pong_trace_buffer_unit regression: pass");
    end else begin
      $display("ping_pong_trace_buffer_unit regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
hdl/ppt_pkg.sv
hdl/ppt_ctrl.sv
hdl/ppt_datapath.sv
hdl/ping_pong_trace_buffer_unit.sv
verif/ping_pong_trace_buffer_unit_test.sv
